@@ design/xtea_like_block_cipher_defines.svh @@
// Assertion helpers for the cipher RTL.
`ifndef XTEA_LIKE_BLOCK_CIPHER_DEFINES_SVH
`define XTEA_LIKE_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define XLBC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xlbc check failed");

// Next-cycle implication, checked while out of reset.
`define XLBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xlbc check failed");

`endif

@@ design/xlbc_pkg.sv @@
package xlbc_pkg;

	localparam int XLBC_MAX_ROUNDS = 29;
	localparam int XLBC_ROUNDS     = 29;

	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	// Two round keys per round, first round first.
	localparam logic [31:0] ROUND_KEYS [0:2*XLBC_MAX_ROUNDS-1] = '{
		32'h363DDF8A, 32'hE3707311, 32'h0E879FDD, 32'h24BEA3C7,
		32'h9B7E408B, 32'h3074528A, 32'hC6445404, 32'hA35E8A61,
		32'h99B3FD42, 32'h4DF979E2, 32'h1F8C4B0E, 32'h1447FFFA,
		32'h8B99BBFD, 32'hAF5F33D7, 32'h2F51FB8C, 32'hADC702EB,
		32'hB5A5319C, 32'h33984815, 32'h41535A36, 32'hE657EB0B,
		32'hA4B199FF, 32'hD1C6CD38, 32'hBF583A5E, 32'h930ABA46,
		32'hD72C79D9, 32'h6BFEFE79, 32'hC078D7C2, 32'h4E7543D1,
		32'h4CD7A6F5, 32'h86E471D0, 32'hA3AF0F50, 32'h5347B2A8,
		32'h32C531A5, 32'h6917DC30, 32'h47BB052F, 32'hCBF37B13,
		32'hD78FCCAA, 32'hB69B15D6, 32'h13CE1C8E, 32'h38FEA0C8,
		32'h4B0F668A, 32'h680AFFA0, 32'h6F6DCF36, 32'h4D5B77E0,
		32'hAE297FA2, 32'hF059DF29, 32'h4C598EFB, 32'hE006177F,
		32'h60F2E72D, 32'h9060FA96, 32'h7B264647, 32'h69982847,
		32'hB2722356, 32'h586C7009, 32'hA2208796, 32'h1DB31180,
		32'hF6CBF07E, 32'h8FE301BC
	};

	// Little-endian words of the fixed 64-byte key string.
	localparam logic [31:0] KEY_WORDS [0:15] = '{
		32'h206D2749, 32'h69622061, 32'h61662067, 32'h666F206E,
		32'h70657320, 32'h6D657974, 32'h37633634, 32'h66336265,
		32'h63383538, 32'h66373331, 32'h66646239, 32'h65356166,
		32'h38386630, 32'h39386530, 32'h62623935, 32'h35366532
	};

	// One pipeline slot: u starts as the upper input word, v as the lower.
	typedef struct packed {
		logic        valid;
		logic        dir;
		logic [31:0] u;
		logic [31:0] v;
	} xlbc_stage_t;

	function automatic logic [31:0] xlbc_mix(input logic [31:0] x, input logic [31:0] rk);
		logic [31:0] kw;
		kw = KEY_WORDS[x[3:0]];
		return (rk + kw) ^ (x + ((x >> 5) ^ (x << 4)));
	endfunction

endpackage

@@ design/xlbc_half_round.sv @@
module xlbc_half_round #(
	parameter int STEP  = 0,
	parameter int STEPS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xlbc_pkg::xlbc_stage_t stage_in,
	output xlbc_pkg::xlbc_stage_t stage_out
);
	import xlbc_pkg::*;

	// Decryption walks the key schedule from the far end.
	localparam logic [31:0] RK_ENC  = ROUND_KEYS[STEP];
	localparam logic [31:0] RK_DEC  = ROUND_KEYS[STEPS-1-STEP];
	localparam bit          UPD_V   = (STEP % 2) == 1;

	logic [31:0] rk;
	logic [31:0] src;
	logic [31:0] dst;
	logic [31:0] mixed;
	logic [31:0] dst_next;

	logic        valid_s1;
	logic        dir_s1;
	logic [31:0] u_s1;
	logic [31:0] v_s1;

	always_comb begin
		rk       = (stage_in.dir == REQ_DECRYPT) ? RK_DEC : RK_ENC;
		src      = UPD_V ? stage_in.u : stage_in.v;
		dst      = UPD_V ? stage_in.v : stage_in.u;
		mixed    = xlbc_mix(src, rk);
		dst_next = (stage_in.dir == REQ_DECRYPT) ? (dst - mixed) : (dst + mixed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		dir_s1 <= stage_in.dir;
		u_s1   <= UPD_V ? stage_in.u : dst_next;
		v_s1   <= UPD_V ? dst_next : stage_in.v;
	end

	assign stage_out = '{valid: valid_s1, dir: dir_s1, u: u_s1, v: v_s1};

endmodule

@@ design/xtea_like_block_cipher.sv @@
// XTEA-like block cipher, fully unrolled: one half-round per register stage, 2*ROUNDS
// stages (58 at the default of 29 rounds). A block is taken on every cycle with start
// high and busy low; its result appears on block_out with done high, one cycle wide,
// after all half-round stages; the receiver cannot stall, so results must be
// taken when done pulses. Throughput is one block per cycle while busy is low, set by
// the unrolled stage chain. busy is high from reset until clocked low. req_type 0
// encrypts (upper word h, lower word p, out p:h); 1 decrypts (in p:h, out h:p).
`include "xtea_like_block_cipher_defines.svh"

module xtea_like_block_cipher #(
	parameter int ROUNDS = xlbc_pkg::XLBC_ROUNDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [63:0] block_in,
	output logic        done,
	output logic [63:0] block_out
);
	import xlbc_pkg::*;

	localparam int EFF_ROUNDS = (ROUNDS < 1) ? 1 :
		((ROUNDS > XLBC_MAX_ROUNDS) ? XLBC_MAX_ROUNDS : ROUNDS);
	localparam int STEPS = 2 * EFF_ROUNDS;

	logic        busy_q;
	logic        in_xfer;
	xlbc_stage_t pipe [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy    = busy_q;
	assign in_xfer = start & ~busy_q;
	assign pipe[0] = '{valid: in_xfer, dir: req_type, u: block_in[63:32], v: block_in[31:0]};

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		xlbc_half_round #(
			.STEP  (i),
			.STEPS (STEPS)
		) u_half_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (pipe[i]),
			.stage_out (pipe[i+1])
		);
	end

	// Both directions leave the halves in the same slots: v goes out on top.
	assign done      = pipe[STEPS].valid;
	assign block_out = {pipe[STEPS].v, pipe[STEPS].u};

	`XLBC_ASSERT_IMPLY(a_done_has_source, done, $past(in_xfer, STEPS))
	`XLBC_ASSERT_IMPLY(a_source_gives_done, $past(in_xfer, STEPS), done)
	`XLBC_ASSERT_NEXT(a_busy_drops, arst_n, !busy)

endmodule

@@ verif/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xlbc_pkg::*;

	localparam int CIPHER_ROUNDS = XLBC_ROUNDS;
	localparam int LIVE_ROUNDS   = (CIPHER_ROUNDS < 1) ? 1 :
		((CIPHER_ROUNDS > XLBC_MAX_ROUNDS) ? XLBC_MAX_ROUNDS : CIPHER_ROUNDS);
	localparam int PIPE_DEPTH    = 2 * LIVE_ROUNDS;
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        req_type = REQ_ENCRYPT;
	logic [63:0] block_in = '0;
	logic        busy;
	logic        done;
	logic [63:0] block_out;

	logic [63:0] pending_blocks[$];
	logic [63:0] want_block;
	int          mismatches = 0;
	int          cycle_count = 0;

	xtea_like_block_cipher #(.ROUNDS(CIPHER_ROUNDS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.block_in (block_in),
		.done     (done),
		.block_out(block_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Key-dependent term added to (or, to decrypt, taken from) one half, driven by the other half.
	function automatic logic [31:0] half_round_term(input logic [31:0] other,
		input logic [31:0] rkey);
		logic [31:0] diffused;
		logic [31:0] keyed;
		diffused = other + ((other << 4) ^ (other >> 5));
		keyed    = rkey + KEY_WORDS[other[3:0]];
		return diffused ^ keyed;
	endfunction

	function automatic logic [63:0] xtea_expected(input logic dir, input logic [63:0] blk);
		logic [31:0] h;
		logic [31:0] p;
		int r;
		if (dir == REQ_ENCRYPT) begin
			h = blk[63:32];
			p = blk[31:0];
			for (r = 0; r < LIVE_ROUNDS; r++) begin
				h = h + half_round_term(p, ROUND_KEYS[2*r]);
				p = p + half_round_term(h, ROUND_KEYS[2*r+1]);
			end
			return {p, h};
		end else begin
			p = blk[63:32];
			h = blk[31:0];
			for (r = LIVE_ROUNDS - 1; r >= 0; r--) begin
				p = p - half_round_term(h, ROUND_KEYS[2*r+1]);
				h = h - half_round_term(p, ROUND_KEYS[2*r]);
			end
			return {h, p};
		end
	endfunction

	function automatic logic [63:0] random_block();
		return {$urandom, $urandom};
	endfunction

	// Check results first, then record the expectation of a transfer at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_blocks.size() == 0) begin
					$display("%0t: result with nothing pending: expected none, got %h",
						$time, block_out);
					mismatches++;
				end else begin
					want_block = pending_blocks.pop_front();
					if (block_out !== want_block) begin
						$display("%0t: block_out mismatch: expected %h, got %h",
							$time, want_block, block_out);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				pending_blocks.push_back(xtea_expected(req_type, block_in));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** xtea_like_block_cipher: FAILED **");
			$finish;
		end
	end

	// Hold start high until the transfer; leave it high for a back-to-back follower.
	task automatic send_block(input logic dir, input logic [63:0] blk);
		start    <= 1'b1;
		req_type <= dir;
		block_in <= blk;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if ($urandom_range(0, 99) < 10) begin
			if ($urandom_range(0, 99) == 0)
				idle_cycles($urandom_range(1, PIPE_DEPTH));
			else
				idle_cycles(1);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		logic [63:0] corners[7];
		int i;
		corners = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
			64'hFFFF_FFFF_0000_0000, 64'h8000_0000_0000_0001,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
		for (i = 0; i < 7; i++) begin
			send_block(REQ_ENCRYPT, corners[i]);
			send_block(REQ_DECRYPT, corners[i]);
		end
		idle_cycles(1);
	endtask

	// Decrypting a ciphertext must give the plaintext back.
	task automatic test_round_trips();
		logic [63:0] plain;
		int i;
		for (i = 0; i < 4; i++) begin
			plain = random_block();
			send_block(REQ_ENCRYPT, plain);
			send_block(REQ_DECRYPT, xtea_expected(REQ_ENCRYPT, plain));
		end
		idle_cycles(1);
	endtask

	task automatic test_random_traffic(input int count, input bit with_gaps);
		logic [63:0] plain;
		int i;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: begin
					plain = random_block();
					send_block(REQ_ENCRYPT, plain);
					send_block(REQ_DECRYPT, xtea_expected(REQ_ENCRYPT, plain));
					i++;
				end
				1: send_block(REQ_ENCRYPT, random_block());
				2: send_block(REQ_DECRYPT, random_block());
				default: send_block(1'($urandom_range(0, 1)), random_block());
			endcase
			if (with_gaps)
				maybe_idle();
		end
		idle_cycles(1);
	endtask

	task automatic test_drain_pause();
		test_random_traffic(40, 1'b0);
		wait_drained();
		test_random_traffic(10, 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_round_trips();
		test_random_traffic(800, 1'b1);
		test_drain_pause();
		test_random_traffic(350, 1'b0);
		test_random_traffic(600, 1'b1);

		wait_drained();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mismatches == 0 && pending_blocks.size() == 0)
			$display("** xtea_like_block_cipher: PASSED **");
		else
			$display("** xtea_like_block_cipher: FAILED **");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/xlbc_pkg.sv
design/xlbc_half_round.sv
design/xtea_like_block_cipher.sv
verif/tb.sv
